// ----- rtl/core/bca_pkg.sv -----
package bca_pkg;

	localparam int NUM_CHUNKS   = 4096;
	localparam int CHUNK_BYTES  = 64;
	localparam int HEADER_BYTES = 8;
	localparam int WORD_BITS    = 32;
	localparam int NUM_WORDS    = NUM_CHUNKS / WORD_BITS;

	localparam int ADDR_W  = 48;
	localparam int CHUNK_W = $clog2(NUM_CHUNKS);
	localparam int WORD_W  = $clog2(NUM_WORDS);
	localparam int BIT_W   = $clog2(WORD_BITS);
	localparam int CLOG2_B = $clog2(CHUNK_BYTES);
	localparam int CNT_W   = 13;
	localparam int SIZE_W  = 19;
	localparam int ALIGN_W = 4;
	localparam int AMASK_W = 15;

	localparam logic [WORD_BITS-1:0] FULL_WORD = 32'hFFFF_FFFF;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_OOM     = 2'd1,
		ST_IGNORED = 2'd2,
		ST_BADFREE = 2'd3
	} status_t;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic CFG_REGION_START = 1'b0;
	localparam logic CFG_REGION_END   = 1'b1;

	// Controller to datapath
	typedef struct packed {
		logic    load;
		logic    scan_init;
		logic    free_s1;
		logic    free_s2;
		logic    len_rd;
		logic    len_chk;
		logic    word_rd;
		logic    skip;
		logic    bit_step;
		logic    walk_init;
		logic    walk_next;
		logic    word_wr;
		logic    commit_alloc;
		logic    commit_free;
		logic    out_load;
		status_t status;
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic is_free;
		logic out_range;
		logic len_bad;
		logic word_full;
		logic last_word;
		logic last_bit;
		logic found;
		logic walk_last;
		logic verify_bad;
		logic out_busy;
	} dp_sts_t;

endpackage

// ----- rtl/core/bca_ctrl.sv -----
module bca_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  bca_pkg::dp_sts_t sts,
	output bca_pkg::dp_cmd_t cmd
);
	import bca_pkg::*;

	typedef enum logic [3:0] {
		IDLE, DECODE, F_B, F_C, F_D, S_RD, S_CHK, S_BIT,
		W_INIT, W_RD, W_CHK, FIN, DONE
	} state_t;

	state_t  state_q;
	logic    verify_q;
	status_t status_q;

	assign in_ready = (state_q == IDLE);

	// Decode commands from the current state
	always_comb begin
		cmd = '0;
		cmd.status = status_q;
		case (state_q)
			IDLE:   cmd.load = in_valid;
			DECODE: begin
				cmd.free_s1   = sts.is_free;
				cmd.scan_init = !sts.is_free;
			end
			F_B:    cmd.free_s2 = 1'b1;
			F_C:    cmd.len_rd = !sts.out_range;
			F_D:    cmd.len_chk = 1'b1;
			S_RD:   cmd.word_rd = 1'b1;
			S_CHK:  cmd.skip = sts.word_full;
			S_BIT:  cmd.bit_step = 1'b1;
			W_INIT: cmd.walk_init = 1'b1;
			W_RD:   cmd.word_rd = 1'b1;
			W_CHK: begin
				cmd.word_wr   = !verify_q;
				cmd.walk_next = !sts.walk_last && !(verify_q && sts.verify_bad);
			end
			FIN: begin
				cmd.commit_alloc = !sts.is_free;
				cmd.commit_free  = sts.is_free;
			end
			DONE:   cmd.out_load = !sts.out_busy;
			default: ;
		endcase
	end

	// Hold state, phase and result status
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= IDLE;
			verify_q <= 1'b0;
			status_q <= ST_OK;
		end else begin
			case (state_q)
				IDLE: if (in_valid) state_q <= DECODE;
				DECODE: state_q <= sts.is_free ? F_B : S_RD;
				F_B: state_q <= F_C;
				F_C: begin
					if (sts.out_range) begin
						status_q <= ST_IGNORED;
						state_q  <= DONE;
					end else begin
						state_q <= F_D;
					end
				end
				F_D: begin
					if (sts.len_bad) begin
						status_q <= ST_BADFREE;
						state_q  <= DONE;
					end else begin
						verify_q <= 1'b1;
						state_q  <= W_INIT;
					end
				end
				S_RD: state_q <= S_CHK;
				S_CHK: begin
					if (!sts.word_full) begin
						state_q <= S_BIT;
					end else if (sts.last_word) begin
						status_q <= ST_OOM;
						state_q  <= DONE;
					end else begin
						state_q <= S_RD;
					end
				end
				S_BIT: begin
					if (sts.found) begin
						verify_q <= 1'b0;
						state_q  <= W_INIT;
					end else if (sts.last_bit) begin
						if (sts.last_word) begin
							status_q <= ST_OOM;
							state_q  <= DONE;
						end else begin
							state_q <= S_RD;
						end
					end
				end
				W_INIT: state_q <= W_RD;
				W_RD: state_q <= W_CHK;
				W_CHK: begin
					if (verify_q) begin
						if (sts.verify_bad) begin
							status_q <= ST_BADFREE;
							state_q  <= DONE;
						end else if (sts.walk_last) begin
							verify_q <= 1'b0;
							state_q  <= W_INIT;
						end else begin
							state_q <= W_RD;
						end
					end else begin
						state_q <= sts.walk_last ? FIN : W_RD;
					end
				end
				FIN: begin
					status_q <= ST_OK;
					state_q  <= DONE;
				end
				DONE: if (!sts.out_busy) state_q <= IDLE;
				default: state_q <= IDLE;
			endcase
		end
	end

endmodule

// ----- rtl/core/bca_dp.sv -----
module bca_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [bca_pkg::ADDR_W-1:0]    cfg_data,
	input  logic                          in_op,
	input  logic [bca_pkg::SIZE_W-1:0]    in_size,
	input  logic [bca_pkg::ALIGN_W-1:0]   in_align,
	input  logic [bca_pkg::ADDR_W-1:0]    in_addr,
	input  bca_pkg::dp_cmd_t              cmd,
	output bca_pkg::dp_sts_t              sts,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [1:0]                    out_status,
	output logic [bca_pkg::ADDR_W-1:0]    out_addr,
	output logic [bca_pkg::CNT_W-1:0]     out_used
);
	import bca_pkg::*;

	// Configuration and request registers
	logic [ADDR_W-1:0]  rs_q, re_q;
	logic               op_q;
	logic [ADDR_W-1:0]  ua_q;
	logic [CNT_W-1:0]   need_q;
	logic [AMASK_W-1:0] amask_q;

	// Free address checks
	logic               oor_q;
	logic [ADDR_W-1:0]  um8_q, base_q;
	logic               oor2_q;

	// Scan and walk
	logic [WORD_W-1:0]  w_q;
	logic [BIT_W-1:0]   b_q;
	logic               have_q;
	logic [CNT_W-1:0]   avail_q;
	logic [CHUNK_W-1:0] start_q, lo_q, hi_q;
	logic [ADDR_W-1:0]  cur_q, saddr_q;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   len_q;

	// Memories
	logic [WORD_BITS-1:0] bm_mem [NUM_WORDS];
	logic [NUM_WORDS-1:0] row_valid_q;
	logic [WORD_BITS-1:0] rdata_q;
	logic                 rvalid_q;
	logic [CNT_W-1:0]     len_mem [NUM_CHUNKS];

	logic                 out_valid_q;
	logic [1:0]           out_status_q;
	logic [ADDR_W-1:0]    out_addr_q;
	logic [CNT_W-1:0]     out_used_q;

	logic [WORD_BITS-1:0] word;
	logic [CHUNK_W-1:0]   chunk, first, ns;
	logic                 bit_used, aligned, nh, found, start_new;
	logic [CNT_W-1:0]     na;
	logic [CNT_W:0]       len_end;
	logic [BIT_W-1:0]     lo_b, hi_b;
	logic [WORD_BITS-1:0] mask, wr_data;
	logic [CNT_W-1:0]     hi_alloc;
	logic [ADDR_W-1:0]    size_sum;

	assign word     = rvalid_q ? rdata_q : '0;
	assign chunk    = {w_q, b_q};
	assign first    = base_q[CLOG2_B +: CHUNK_W];
	assign bit_used = word[b_q];
	assign aligned  = ((cur_q[AMASK_W-1:0] & amask_q) == '0);
	assign len_end  = {2'b00, lo_q} + {1'b0, len_q};
	assign size_sum = ADDR_W'(in_size) + ADDR_W'(HEADER_BYTES + CHUNK_BYTES - 1);

	// Next run state for one chunk of the scan
	always_comb begin
		nh        = have_q;
		na        = avail_q;
		start_new = 1'b0;
		if (bit_used) begin
			nh = 1'b0;
			na = '0;
		end else if (!have_q && aligned) begin
			nh        = 1'b1;
			na        = CNT_W'(1);
			start_new = 1'b1;
		end else if (have_q) begin
			na = avail_q + CNT_W'(1);
		end
	end
	assign found    = nh && (na >= need_q);
	assign ns       = start_new ? chunk : start_q;
	assign hi_alloc = {1'b0, ns} + need_q - CNT_W'(1);

	// Mask of the run's chunks within the current word
	assign lo_b    = (w_q == lo_q[CHUNK_W-1 -: WORD_W]) ? lo_q[BIT_W-1:0] : '0;
	assign hi_b    = (w_q == hi_q[CHUNK_W-1 -: WORD_W]) ? hi_q[BIT_W-1:0] : '1;
	assign mask    = (FULL_WORD << lo_b) & (FULL_WORD >> (BIT_W'(WORD_BITS - 1) - hi_b));
	assign wr_data = op_q ? (word & ~mask) : (word | mask);

	// Status to the controller
	always_comb begin
		sts            = '0;
		sts.is_free    = op_q;
		sts.out_range  = oor2_q || (base_q[ADDR_W-1:CLOG2_B+CHUNK_W] != '0);
		sts.len_bad    = (len_q == '0) || (len_end > (CNT_W+1)'(NUM_CHUNKS));
		sts.word_full  = (word == FULL_WORD);
		sts.last_word  = (w_q == WORD_W'(NUM_WORDS - 1));
		sts.last_bit   = (b_q == BIT_W'(WORD_BITS - 1));
		sts.found      = found;
		sts.walk_last  = (w_q == hi_q[CHUNK_W-1 -: WORD_W]);
		sts.verify_bad = ((word & mask) != mask);
		sts.out_busy   = out_valid_q && !out_ready;
	end

	// Hold configuration, scan control and used count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rs_q        <= '0;
			re_q        <= '0;
			w_q         <= '0;
			b_q         <= '0;
			have_q      <= 1'b0;
			avail_q     <= '0;
			count_q     <= '0;
			row_valid_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we && cfg_index == CFG_REGION_START) rs_q <= cfg_data;
			if (cfg_we && cfg_index == CFG_REGION_END)   re_q <= cfg_data;
			if (cmd.scan_init) begin
				w_q     <= '0;
				b_q     <= '0;
				have_q  <= 1'b0;
				avail_q <= '0;
			end
			if (cmd.skip) begin
				w_q     <= w_q + WORD_W'(1);
				have_q  <= 1'b0;
				avail_q <= '0;
			end
			if (cmd.bit_step) begin
				have_q  <= nh;
				avail_q <= na;
				b_q     <= b_q + BIT_W'(1);
				if (b_q == BIT_W'(WORD_BITS - 1)) w_q <= w_q + WORD_W'(1);
			end
			if (cmd.walk_init) w_q <= lo_q[CHUNK_W-1 -: WORD_W];
			if (cmd.walk_next) w_q <= w_q + WORD_W'(1);
			if (cmd.word_wr) row_valid_q[w_q] <= 1'b1;
			if (cmd.commit_alloc) count_q <= count_q + need_q;
			if (cmd.commit_free)  count_q <= count_q - len_q;
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// Advance request, address and run payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= in_op;
			ua_q    <= in_addr;
			need_q  <= size_sum[CLOG2_B +: CNT_W];
			amask_q <= AMASK_W'((16'd1 << in_align) - 16'd1);
		end
		if (cmd.scan_init) cur_q <= rs_q + ADDR_W'(HEADER_BYTES);
		if (cmd.skip) cur_q <= cur_q + ADDR_W'(WORD_BITS * CHUNK_BYTES);
		if (cmd.bit_step) begin
			cur_q <= cur_q + ADDR_W'(CHUNK_BYTES);
			if (start_new) begin
				start_q <= chunk;
				saddr_q <= cur_q;
			end
			if (found) begin
				lo_q <= ns;
				hi_q <= hi_alloc[CHUNK_W-1:0];
			end
		end
		if (cmd.free_s1) begin
			oor_q <= (ua_q < rs_q) || (ua_q >= re_q) || (ua_q < ADDR_W'(HEADER_BYTES));
			um8_q <= ua_q - ADDR_W'(HEADER_BYTES);
		end
		if (cmd.free_s2) begin
			oor2_q <= oor_q || (um8_q < rs_q);
			base_q <= um8_q - rs_q;
		end
		if (cmd.len_rd) lo_q <= first;
		if (cmd.len_chk) hi_q <= CHUNK_W'(len_end - (CNT_W+1)'(1));
		if (cmd.out_load) begin
			out_status_q <= cmd.status;
			out_addr_q   <= (cmd.status == ST_OK && !op_q) ? saddr_q : '0;
			out_used_q   <= count_q;
		end
	end

	// Bitmap memory with valid rows
	always_ff @(posedge clk) begin
		if (cmd.word_rd) begin
			rdata_q  <= bm_mem[w_q];
			rvalid_q <= row_valid_q[w_q];
		end
		if (cmd.word_wr) bm_mem[w_q] <= wr_data;
	end

	// Run length memory
	always_ff @(posedge clk) begin
		if (cmd.len_rd) len_q <= len_mem[first];
		if (cmd.commit_alloc) len_mem[lo_q] <= need_q;
		if (cmd.commit_free)  len_mem[lo_q] <= '0;
	end

	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_addr   = out_addr_q;
	assign out_used   = out_used_q;

endmodule

// ----- rtl/core/bitmap_chunk_allocator.sv -----
// First-fit chunk allocator over 4096 chunks of 64 bytes, tracked in a 128 x 32 bitmap
// memory that reads as all free after reset; no clearing pass is needed. An allocate
// scans the bitmap from chunk 0: each word is fetched and tested, a full word is
// skipped there, and each chunk of a word that is not full is tested in its own step.
// Marking or clearing a run then reads and writes back each bitmap word it touches,
// and a free reads each word twice (check, then clear). One request is in work at
// a time; the next is taken while the previous result still waits in the output
// register.
module bitmap_chunk_allocator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// operation[0], size_bytes[19:1], align_log2[23:20], user_address[71:24]
	input  logic [71:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// status[1:0], result_address[49:2], used_chunks[62:50], zero[63]
	output logic [63:0] m_tdata,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [47:0] cfg_data
);
	import bca_pkg::*;

	dp_cmd_t            cmd;
	dp_sts_t            sts;
	logic [1:0]         out_status;
	logic [ADDR_W-1:0]  out_addr;
	logic [CNT_W-1:0]   out_used;

	bca_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	bca_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_op      (s_tdata[0]),
		.in_size    (s_tdata[19:1]),
		.in_align   (s_tdata[23:20]),
		.in_addr    (s_tdata[71:24]),
		.cmd        (cmd),
		.sts        (sts),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_status (out_status),
		.out_addr   (out_addr),
		.out_used   (out_used)
	);

	assign m_tdata = {1'b0, out_used, out_addr, out_status};

endmodule

// ----- rtl/core/bca_checker.sv -----
module bca_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [63:0] m_tdata
);
	import bca_pkg::*;

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

	// Drop ready after an item is taken
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second item taken while busy");

	// Only a good allocate returns an address
	a_addr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1:0] != ST_OK |-> m_tdata[49:2] == '0)
		else $error("address on failed request");

	// No result without a request in work
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid && s_tready && !s_tvalid |=> !m_tvalid)
		else $error("result without request");

endmodule

bind bitmap_chunk_allocator bca_checker u_bca_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
